@@ rtl/core/pidaw_pkg.sv @@
// Package for the PID controller with conditional-integration anti-windup.
// Holds payload structs, register indexes, widths and shared constants.
// No dependencies.
package pidaw_pkg;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               integrated;
  } out_beat_t;

  typedef enum logic [2:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_DT  = 3'd3,
    REG_LIM = 3'd4
  } reg_idx_t;

  localparam int unsigned ADDR_W     = 5;
  localparam logic [15:0] DT_MIN     = 16'd7;
  localparam logic [15:0] DT_RESET   = 16'd66;
  localparam logic [30:0] LIM_RESET  = 31'd10000;
  localparam int unsigned MUL_W      = 64;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned DIV_STEPS  = 64;

endpackage

@@ rtl/core/pidaw_mul.sv @@
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// Depends on pidaw_pkg.
module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MUL_W-1:0]       a,
  input  logic [MUL_W-1:0]       b,
  output logic [MUL_W-1:0]       p,
  output logic                   done
);

  logic [MUL_W-1:0]     acc_r, acc_nxt;
  logic [MUL_W-1:0]     mc_r, mc_nxt;
  logic [MUL_W-1:0]     mp_r, mp_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = a;
      mp_nxt   = b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt = {mc_r[MUL_W-2:0], 1'b0};
      mp_nxt = {1'b0, mp_r[MUL_W-1:1]};
      if (mp_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign p    = acc_r;
  assign done = done_r;

endmodule

@@ rtl/core/pidaw_div.sv @@
// Restoring bit-serial divider: one quotient bit per cycle, 64 steps.
// Depends on pidaw_pkg.
module pidaw_div
  import pidaw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   num,
  input  logic [15:0]        den,
  output logic [DIV_W-1:0]   quo,
  output logic               done
);

  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [16:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [16:0]          trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], q_r[DIV_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

@@ rtl/core/pid_controller_conditional_antiwindup_unit.sv @@
// PID controller with conditional-integration anti-windup, bit-serial datapath.
// Clear beats skip the arithmetic; control-step duration is set by operand bit
// lengths in the shift-add multiplier and by the 64-step restoring divider, which
// is skipped below a sample period of 7.
// One item at a time; the next beat is taken the cycle after the result beat leaves.
// Reset (rst_n low, synchronous) zeroes gains, integral, previous error. Needs pidaw_pkg.
module pid_controller_conditional_antiwindup_unit
  import pidaw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_KP, S_KPW, S_KD, S_KDW, S_DIV, S_DIVW, S_KI1, S_KI1W, S_KI2, S_KI2W,
    S_FIN, S_SUM, S_DRV, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] kp_r, ki_r, kd_r;
  logic [15:0] dt_r;
  logic [30:0] lim_r;
  logic signed [47:0] integ_r;
  logic signed [16:0] lerr_r;
  logic signed [16:0] err_r;
  logic signed [63:0] prop_r, deriv_r, tent_r, total_r;
  logic        dneg_r, ineg_r;
  logic [63:0] tmp_r;
  out_beat_t   out_r;
  logic        ovalid_r;

  logic             mul_start, mul_done, div_start, div_done;
  logic [63:0]      mul_a, mul_b, mul_p, div_q;
  logic [2:0]       reg_sel;
  logic             wr_en;

  assign reg_sel    = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_KP:  cfg_prdata = kp_r;
      REG_KI:  cfg_prdata = ki_r;
      REG_KD:  cfg_prdata = kd_r;
      REG_DT:  cfg_prdata = {16'd0, dt_r};
      REG_LIM: cfg_prdata = {1'b0, lim_r};
      default: cfg_prdata = '0;
    endcase
  end

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : v;
  endfunction

  logic signed [63:0] kp_s, ki_s, kd_s, err_s, diff_s;
  logic signed [63:0] inc_s, ni;
  logic [63:0]        tmag, tlim, tot_mag;
  logic               opposes, do_int;
  logic signed [63:0] ipart;

  assign kp_s   = 64'(signed'(kp_r));
  assign ki_s   = 64'(signed'(ki_r));
  assign kd_s   = 64'(signed'(kd_r));
  assign err_s  = 64'(err_r);
  assign diff_s = 64'(err_r) - 64'(lerr_r);

  assign tmag    = mag64(tent_r);
  assign tlim    = {17'd0, lim_r, 16'd0};
  assign opposes = (err_r == '0) || (tent_r == '0) || (err_r[16] != tent_r[63]);
  assign do_int  = (ki_r != '0) && ((tmag < tlim) || opposes);
  assign inc_s   = ineg_r ? -$signed({16'd0, tmp_r[63:16]}) : $signed({16'd0, tmp_r[63:16]});

  always_comb begin
    ni = 64'(integ_r) + inc_s;
    if (ni > 64'sh7FFF_FFFF_FFFF)  ni = 64'sh7FFF_FFFF_FFFF;
    if (ni < -64'sh8000_0000_0000) ni = -64'sh8000_0000_0000;
  end

  logic signed [47:0] integ_use;
  assign integ_use = do_int ? ni[47:0] : integ_r;
  assign tot_mag   = mag64(total_r) >> 16;

  always_comb begin
    ipart = total_r[63] ? -$signed(tot_mag) : $signed(tot_mag);
    if (ipart > 64'sd2147483647)  ipart = 64'sd2147483647;
    if (ipart < -64'sd2147483648) ipart = -64'sd2147483648;
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_KP: begin
        mul_start = 1'b1;
        mul_a = mag64(kp_s);
        mul_b = mag64(err_s);
      end
      S_KD: begin
        mul_start = 1'b1;
        mul_a = mag64(kd_s);
        mul_b = mag64(diff_s);
      end
      S_DIV:  div_start = 1'b1;
      S_KI1: begin
        mul_start = 1'b1;
        mul_a = mag64(ki_s);
        mul_b = mag64(err_s);
      end
      S_KI2: begin
        mul_start = 1'b1;
        mul_a = tmp_r;
        mul_b = {48'd0, dt_r};
      end
      default: ;
    endcase
  end

  pidaw_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .p(mul_p), .done(mul_done)
  );

  pidaw_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num({tmp_r[47:0], 16'd0}),
    .den(dt_r), .quo(div_q), .done(div_done)
  );

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      dt_r     <= DT_RESET;
      lim_r    <= LIM_RESET;
      integ_r  <= '0;
      lerr_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (reg_sel)
          REG_KP:  kp_r  <= cfg_pwdata;
          REG_KI:  ki_r  <= cfg_pwdata;
          REG_KD:  kd_r  <= cfg_pwdata;
          REG_DT:  dt_r  <= cfg_pwdata[15:0];
          REG_LIM: lim_r <= cfg_pwdata[30:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.cmd) begin
              integ_r <= '0;
              lerr_r  <= '0;
              out_r   <= '0;
              state_r <= S_OUT;
            end else begin
              err_r   <= 17'(in_data.target) - 17'(in_data.measured);
              state_r <= S_KP;
            end
          end
        end
        S_KP: state_r <= S_KPW;
        S_KPW: begin
          if (mul_done) begin
            prop_r  <= (kp_r[31] ^ err_r[16]) ? -$signed(mul_p) : $signed(mul_p);
            deriv_r <= '0;
            state_r <= (dt_r >= DT_MIN) ? S_KD : S_KI1;
          end
        end
        S_KD: begin
          dneg_r  <= (kd_r[31] ^ diff_s[63]) && (kd_r != '0) && (diff_s != '0);
          state_r <= S_KDW;
        end
        S_KDW: begin
          if (mul_done) begin
            tmp_r   <= mul_p;
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            deriv_r <= dneg_r ? -$signed(div_q) : $signed(div_q);
            state_r <= S_KI1;
          end
        end
        S_KI1: begin
          ineg_r  <= (ki_r[31] != err_r[16]) && (err_r != '0);
          tent_r  <= prop_r + 64'(integ_r) + deriv_r;
          state_r <= S_KI1W;
        end
        S_KI1W: begin
          if (mul_done) begin
            tmp_r   <= mul_p;
            state_r <= S_KI2;
          end
        end
        S_KI2: state_r <= S_KI2W;
        S_KI2W: begin
          if (mul_done) begin
            tmp_r   <= mul_p;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          integ_r          <= integ_use;
          lerr_r           <= err_r;
          out_r.integrated <= do_int;
          state_r          <= S_SUM;
        end
        S_SUM: begin
          total_r <= prop_r + 64'(integ_r) + deriv_r;
          state_r <= S_DRV;
        end
        S_DRV: begin
          out_r.drive <= ipart[31:0];
          state_r     <= S_OUT;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sim/tb_pid_controller_conditional_antiwindup_unit.sv @@
// Testbench for pid_controller_conditional_antiwindup_unit: drives control and clear
// beats, predicts drive and integration flag per beat, compares every result beat.
// Depends on pidaw_pkg and the unit RTL.
module tb_pid_controller_conditional_antiwindup_unit
  import pidaw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pid_controller_conditional_antiwindup_unit i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic [15:0] dt_q;
  logic [30:0] lim_q;
  logic signed [63:0] integ_q;
  logic signed [63:0] prev_err;

  out_beat_t drive_due[$];
  int errors = 0;
  bit stall_on = 1'b1;
  bit hold_off = 1'b0;
  int unsigned quiet = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic out_beat_t predict_drive(input in_beat_t b);
    out_beat_t r;
    logic signed [63:0] err, prop, deriv, tent, total, num, ip, ni;
    logic [63:0] a, q, rm, inc, lim;
    bit neg, opp;
    r = '0;
    if (b.cmd) begin
      integ_q = 0;
      prev_err = 0;
      return r;
    end
    err = 64'(b.target) - 64'(b.measured);
    prop = 64'(kp_q) * err;
    deriv = 0;
    if (dt_q >= DT_MIN) begin
      num = 64'(kd_q) * (err - prev_err);
      a = magn(num);
      q = a / dt_q;
      rm = a % dt_q;
      deriv = (q << 16) + ((rm << 16) / dt_q);
      if (num < 0) deriv = -deriv;
    end
    tent = prop + integ_q + deriv;
    if (ki_q != 0) begin
      lim = 64'(lim_q) << 16;
      opp = (err == 0) || (tent == 0) || ((err < 0) != (tent < 0));
      if (magn(tent) < lim || opp) begin
        neg = (ki_q < 0) != (err < 0);
        if (err == 0) neg = 1'b0;
        inc = (magn(64'(ki_q)) * magn(err) * dt_q) >> 16;
        ni = integ_q + (neg ? -$signed(inc) : $signed(inc));
        if (ni > 64'sh7FFF_FFFF_FFFF) ni = 64'sh7FFF_FFFF_FFFF;
        if (ni < -64'sh8000_0000_0000) ni = -64'sh8000_0000_0000;
        integ_q = ni;
        r.integrated = 1'b1;
      end
    end
    total = prop + integ_q + deriv;
    prev_err = err;
    ip = $signed(magn(total) >> 16);
    if (total < 0) ip = -ip;
    if (ip > 64'sd2147483647) ip = 64'sd2147483647;
    if (ip < -64'sd2147483648) ip = -64'sd2147483648;
    r.drive = ip[31:0];
    return r;
  endfunction

  task automatic send_beat(input in_beat_t b, input bit gaps);
    int n;
    if (gaps && $urandom_range(3) == 0) begin
      n = $urandom_range(17, 1);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    drive_due.push_back(predict_drive(b));
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(4 * idx);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KP: kp_q = val;
      REG_KI: ki_q = val;
      REG_KD: kd_q = val;
      REG_DT: dt_q = val[15:0];
      default: lim_q = val[30:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_gains(input logic [31:0] p, i, d, input logic [15:0] t,
                           input logic [30:0] l);
    drain();
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_DT, {16'h0, t});
    write_reg(REG_LIM, {1'b0, l});
  endtask

  function automatic in_beat_t mk(input bit c, input logic [15:0] t, m);
    in_beat_t b;
    b.cmd = c;
    b.target = t;
    b.measured = m;
    return b;
  endfunction

  function automatic in_beat_t rnd_beat();
    in_beat_t b;
    b = mk($urandom_range(15) == 0, 16'($urandom), 16'($urandom));
    if ($urandom_range(1)) begin
      b.target = $signed(16'($urandom_range(200))) - 16'sd100;
      b.measured = $signed(16'($urandom_range(200))) - 16'sd100;
    end
    return b;
  endfunction

  task automatic test_extremes();
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 16'd66, 31'd10000);
    send_beat(mk(1'b0, 16'h7FFF, 16'h8000), 1'b0);
    send_beat(mk(1'b0, 16'h8000, 16'h7FFF), 1'b0);
    send_beat(mk(1'b0, 16'h0000, 16'h0000), 1'b0);
    send_beat(mk(1'b0, 16'hFFFF, 16'hFFFF), 1'b0);
    send_beat(mk(1'b1, 16'h1234, 16'h4321), 1'b0);
    send_beat(mk(1'b0, 16'h0100, 16'h0000), 1'b0);
    send_beat(mk(1'b0, 16'h0000, 16'h0100), 1'b0);
  endtask

  task automatic test_short_period();
    set_gains(32'h0002_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'd6, 31'd10000);
    send_beat(mk(1'b0, 16'd500, 16'd0), 1'b0);
    send_beat(mk(1'b0, -16'sd500, 16'd0), 1'b0);
    set_gains(32'h0002_0000, 32'h0000_0000, 32'h8000_0000, 16'd7, 31'd10000);
    send_beat(mk(1'b0, 16'd500, 16'd0), 1'b0);
    send_beat(mk(1'b0, -16'sd500, 16'd0), 1'b0);
  endtask

  task automatic test_saturation();
    set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 31'h7FFF_FFFF);
    repeat (6) send_beat(mk(1'b0, 16'h7FFF, 16'h8000), 1'b0);
    set_gains(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd7, 31'd0);
    repeat (4) send_beat(mk(1'b0, 16'h7FFF, 16'h8000), 1'b0);
    send_beat(mk(1'b1, 16'h0, 16'h0), 1'b0);
  endtask

  task automatic test_random(input int n, input bit gaps);
    repeat (n) send_beat(rnd_beat(), gaps);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (8) send_beat(rnd_beat(), 1'b0);
    drain();
  endtask

  task automatic random_config();
    set_gains($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0000_4000),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0000_4000),
              16'($urandom_range(65535, 0)),
              $urandom_range(3) == 0 ? 31'($urandom) : 31'd20000);
  endtask

  // consumer stalls
  always @(posedge clk) begin
    int n;
    if (hold_off) begin
      out_ready <= 1'b0;
      repeat (400) @(posedge clk);
      hold_off <= 1'b0;
    end else if (stall_on && $urandom_range(4) == 0) begin
      out_ready <= 1'b0;
      n = $urandom_range(17, 1);
      repeat (n) @(posedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        report_mismatch("unexpected beat", out_data.drive, 0);
      end else begin
        want = drive_due.pop_front();
        if (out_data.drive !== want.drive)
          report_mismatch("drive", out_data.drive, want.drive);
        if (out_data.integrated !== want.integrated)
          report_mismatch("integrated", out_data.integrated, want.integrated);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_pid_controller_conditional_antiwindup_unit: FAIL");
      $finish;
    end
  end

  initial begin
    kp_q = 0; ki_q = 0; kd_q = 0; dt_q = DT_RESET; lim_q = LIM_RESET;
    integ_q = 0; prev_err = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_beat(mk(1'b0, 16'd100, 16'd0), 1'b0);
    test_extremes();
    test_short_period();
    test_saturation();
    test_backpressure();
    for (int k = 0; k < 16; k++) begin
      random_config();
      test_random(90, 1'b1);
    end
    set_gains(32'h0001_0000, 32'h0000_1000, 32'h0000_0800, 16'd66, 31'd10000);
    stall_on = 1'b0;
    test_random(200, 1'b0);
    drain();
    if (errors == 0) begin
      $display("tb_pid_controller_conditional_antiwindup_unit: PASS");
    end else begin
      $display("tb_pid_controller_conditional_antiwindup_unit: FAIL");
    end
    $finish;
  end
endmodule
